[rtl/generation_tagged_tile_allocator_assert.svh]
// Assertion macros for the tile allocator
`ifndef GENERATION_TAGGED_TILE_ALLOCATOR_ASSERT_SVH
`define GENERATION_TAGGED_TILE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GTTA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define GTTA_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GTTA_ASSERT(label, cond, msg)
`define GTTA_IMPLY(label, pre, post, msg)
`endif
`endif

[rtl/gtta_pkg.sv]
package gtta_pkg;
  localparam int MaxSlots = 4096;
  localparam int Layers = 3;
  localparam int SlotW = $clog2(MaxSlots);
  localparam int CntW = SlotW + 1;
  localparam int MemDepth = 4 * MaxSlots;
  localparam int MemAw = $clog2(MemDepth);
  localparam int NumCfg = 6;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadPal  = 2'd2;

  localparam logic OpReserve = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT, S_SCAN, S_RD, S_FREE, S_DONE
  } state_t;
endpackage

[rtl/gtta_ram.sv]
module gtta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/generation_tagged_tile_allocator.sv]
// Tile-slot allocator for three layers. One item at a time: busy is high from the
// accepting edge until the single result strobe (out_valid, one cycle, not stallable).
// After reset a clearing pass zeroes all 16384 tag entries; busy stays high meanwhile.
// Every item with a valid layer and palette sweeps the layer's slot tag memory through
// one read port at one slot per cycle: a place stops at the first free slot; a reserve
// takes one count sweep plus, for each generation freed, one free-and-count sweep.
// Configuration is only taken while idle.
`include "generation_tagged_tile_allocator_assert.svh"
module generation_tagged_tile_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [1:0]  in_layer,
  input  logic [1:0]  in_position,
  input  logic [12:0] in_tile_count,
  input  logic [6:0]  in_sprite_width,
  input  logic [6:0]  in_column,
  input  logic [5:0]  in_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [12:0] out_free_count,
  output logic [11:0] out_tile_slot,
  output logic [22:0] out_name_word,
  output logic [12:0] out_map_address,
  output logic        out_map_write
);
  localparam int SW = gtta_pkg::SlotW;
  localparam int CW = gtta_pkg::CntW;
  localparam int AW = gtta_pkg::MemAw;

  gtta_pkg::state_t state_r, state_nxt;
  logic [12:0] cap_r [3];
  logic [13:0] base_r [3];
  logic [7:0]  gen_r [3];
  logic        op_r;
  logic [1:0]  ly_r;
  logic [2:0]  pal_r;
  logic [12:0] cnt_r;
  logic [12:0] xaddr_r;
  logic        mw_r;
  logic [CW-1:0] cap_sel_r;
  logic [CW-1:0] idx_r;
  logic          rd_v_r;
  logic [SW-1:0] rd_slot_r;
  logic [CW-1:0] free_r;
  logic [7:0]    g_r;
  logic [AW-1:0] clr_r;

  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  gtta_ram #(.Width(8), .Depth(gtta_pkg::MemDepth)) u_tags (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state_r != gtta_pkg::S_IDLE);
  assign cfg_ready = !busy && !start;

  logic [2:0]  pal_c;
  logic [8:0]  xs_c;
  logic [8:0]  x_c;
  logic [12:0] addr_c;
  logic [12:0] capr_c;
  logic        acc;
  always_comb begin
    pal_c = 3'd1;
    xs_c  = '0;
    if (in_position == 2'd0) begin
      pal_c = 3'd1 + {1'b0, in_layer};
    end else if (in_position == 2'd1) begin
      pal_c = 3'd3 + {1'b0, in_layer};
      xs_c  = 9'd44 - {3'b0, in_sprite_width[6:1]};
    end else if (in_position == 2'd2) begin
      pal_c = 3'd5 + {1'b0, in_layer};
      xs_c  = 9'd88 - {2'b0, in_sprite_width};
    end
    x_c = xs_c + {2'b0, in_column};
    if ($signed(x_c) < 9'sd64) addr_c = {1'b0, in_row, 6'd0} + {{4{x_c[8]}}, x_c};
    else addr_c = {1'b1, in_row, 6'd0} + {4'd0, x_c} - 13'd64;
    capr_c = (in_layer == 2'd3) ? 13'd0 : cap_r[in_layer];
    acc = start && !busy;
  end

  logic last_rd;
  assign last_rd = rd_v_r && ({1'b0, rd_slot_r} == cap_sel_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gtta_pkg::S_CLR:  if (&clr_r) state_nxt = gtta_pkg::S_IDLE;
      gtta_pkg::S_IDLE: if (acc) begin
        if (in_layer == 2'd3 || pal_c > 3'd6) state_nxt = gtta_pkg::S_DONE;
        else if (in_operation == gtta_pkg::OpReserve) state_nxt = gtta_pkg::S_CNT;
        else state_nxt = gtta_pkg::S_SCAN;
      end
      gtta_pkg::S_CNT:  if (last_rd || cap_sel_r == '0) begin
        if (cnt_r > cap_sel_r[12:0] || cnt_r == '0) state_nxt = gtta_pkg::S_DONE;
        else state_nxt = gtta_pkg::S_FREE;
      end
      gtta_pkg::S_FREE: if (last_rd) begin
        if ({1'b0, free_r} + (rdata == g_r || rdata == 8'd0 ? 1'b1 : 1'b0) >= cnt_r)
          state_nxt = gtta_pkg::S_DONE;
        else state_nxt = gtta_pkg::S_FREE;
      end
      gtta_pkg::S_SCAN: if ((rd_v_r && rdata == 8'd0) || last_rd || cap_sel_r == '0)
        state_nxt = gtta_pkg::S_DONE;
      gtta_pkg::S_DONE: state_nxt = gtta_pkg::S_IDLE;
      default: state_nxt = gtta_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = {ly_r, idx_r[SW-1:0]};
    if (state_r == gtta_pkg::S_CLR) begin
      we = 1'b1; waddr = clr_r;
    end else if (state_r == gtta_pkg::S_FREE && rd_v_r && rdata == g_r) begin
      we = 1'b1; waddr = {ly_r, rd_slot_r};
    end else if (state_r == gtta_pkg::S_SCAN && rd_v_r && rdata == 8'd0) begin
      we = 1'b1; waddr = {ly_r, rd_slot_r}; wdata = gen_r[ly_r];
    end
  end

  logic sweep;
  assign sweep = (state_r == gtta_pkg::S_CNT || state_r == gtta_pkg::S_FREE ||
                  state_r == gtta_pkg::S_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtta_pkg::S_CLR;
      clr_r <= '0;
      cap_r[0] <= 13'd3072; cap_r[1] <= 13'd1536; cap_r[2] <= 13'd1536;
      base_r[0] <= '0; base_r[1] <= '0; base_r[2] <= '0;
      gen_r[0] <= '0; gen_r[1] <= '0; gen_r[2] <= '0;
      out_valid <= 1'b0;
      rd_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (state_r == gtta_pkg::S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < 3'd3) cap_r[cfg_index[1:0]] <= cfg_data[12:0];
        else if (cfg_index < 3'd6) base_r[cfg_index[1:0] - 2'd3] <= cfg_data;
      end
      if (state_r == gtta_pkg::S_IDLE && acc) begin
        op_r <= in_operation; ly_r <= in_layer; pal_r <= pal_c;
        cnt_r <= in_tile_count; xaddr_r <= addr_c;
        mw_r <= !(in_layer == 2'd2 && in_row >= 6'd44 && in_row <= 6'd53);
        cap_sel_r <= (capr_c > 13'd4096) ? CW'(4096) : capr_c[CW-1:0];
        idx_r <= '0; rd_v_r <= 1'b0; free_r <= '0;
        out_tile_slot <= '0;
        g_r <= (in_layer == 2'd3) ? 8'd0 : gen_r[in_layer];
        out_status <= (in_layer == 2'd3) ? gtta_pkg::StNoSpace :
                      (pal_c > 3'd6) ? gtta_pkg::StBadPal : gtta_pkg::StOk;
      end
      if (sweep) begin
        rd_v_r <= (idx_r < cap_sel_r);
        rd_slot_r <= idx_r[SW-1:0];
        if (idx_r < cap_sel_r) idx_r <= idx_r + 1'b1;
        if (rd_v_r && (rdata == 8'd0 || (state_r == gtta_pkg::S_FREE && rdata == g_r)))
          free_r <= free_r + 1'b1;
      end
      if (state_r == gtta_pkg::S_CNT && state_nxt != state_r) begin
        if (cnt_r > cap_sel_r[12:0]) out_status <= gtta_pkg::StNoSpace;
        idx_r <= '0; rd_v_r <= 1'b0;
        if (state_nxt == gtta_pkg::S_FREE) begin
          free_r <= '0; g_r <= (g_r == 8'd255) ? 8'd1 : g_r + 1'b1;
        end else if (cnt_r == '0) begin
          free_r <= '0;
        end else begin
          free_r <= free_r + ((rd_v_r && rdata == 8'd0) ? 1'b1 : 1'b0);
        end
      end
      if (state_r == gtta_pkg::S_FREE && last_rd) begin
        idx_r <= '0; rd_v_r <= 1'b0;
        if (state_nxt == gtta_pkg::S_FREE) begin
          free_r <= '0; g_r <= (g_r == 8'd255) ? 8'd1 : g_r + 1'b1;
        end
      end
      if (state_r == gtta_pkg::S_SCAN && state_nxt == gtta_pkg::S_DONE) begin
        if (rd_v_r && rdata == 8'd0) begin
          out_tile_slot <= rd_slot_r;
        end else out_status <= gtta_pkg::StNoSpace;
      end
      if (state_r == gtta_pkg::S_DONE) begin
        out_valid <= 1'b1;
        if (op_r == gtta_pkg::OpReserve && out_status == gtta_pkg::StOk)
          gen_r[ly_r] <= (gen_r[ly_r] == 8'd255) ? 8'd1 : gen_r[ly_r] + 1'b1;
      end
    end
  end

  logic ok_place;
  assign ok_place = (op_r != gtta_pkg::OpReserve) && out_status == gtta_pkg::StOk;
  always_ff @(posedge clk) begin
    if (state_r == gtta_pkg::S_DONE) begin
      out_free_count <= (op_r == gtta_pkg::OpReserve && out_status != gtta_pkg::StBadPal &&
                         ly_r != 2'd3) ? free_r[12:0] : '0;
      out_name_word <= ok_place ? ({pal_r, 20'd0} + {9'd0, base_r[ly_r]} +
                                   {10'd0, out_tile_slot, 1'b0}) : '0;
      out_map_address <= ok_place ? xaddr_r : '0;
      out_map_write <= ok_place && mw_r;
    end
  end

  `GTTA_IMPLY(a_strobe_one, out_valid, !out_valid, "result strobe longer than one cycle")
  `GTTA_IMPLY(a_done_strobe, state_r == gtta_pkg::S_DONE, out_valid, "done without result")
  `GTTA_ASSERT(a_no_strobe_busy, !(out_valid && state_r != gtta_pkg::S_IDLE),
    "result while busy")
  `GTTA_ASSERT(a_write_only_work, !(out_map_write && !out_valid && $past(state_r) ==
    gtta_pkg::S_DONE), "map write without result")
endmodule

[tb/generation_tagged_tile_allocator_checker.sv]
`timescale 1ns / 1ps
module generation_tagged_tile_allocator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [1:0]  in_layer,
  input  logic [1:0]  in_position,
  input  logic [12:0] in_tile_count,
  input  logic [6:0]  in_sprite_width,
  input  logic [6:0]  in_column,
  input  logic [5:0]  in_row,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [12:0] out_free_count,
  input  logic [11:0] out_tile_slot,
  input  logic [22:0] out_name_word,
  input  logic [12:0] out_map_address,
  input  logic        out_map_write,
  output int          mismatches,
  output int          pending
);

  localparam int FirstBaseIdx = 3;
  localparam int TextRowLo = 44;
  localparam int TextRowHi = 53;
  localparam int PalStep = 32'h100000;
  localparam int Pitch = 64;
  localparam int Layers = gtta_pkg::Layers;
  localparam int MaxSlots = gtta_pkg::MaxSlots;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] free_count;
    logic [11:0] tile_slot;
    logic [22:0] name_word;
    logic [12:0] map_address;
    logic        map_write;
  } alloc_result_t;

  logic [7:0]  tags [Layers][MaxSlots];
  logic [7:0]  generation [Layers];
  logic [12:0] capacity [Layers];
  logic [13:0] name_base [Layers];
  alloc_result_t expected_q [$];

  function automatic logic [7:0] next_generation(logic [7:0] g);
    return (g == 8'd255) ? 8'd1 : g + 8'd1;
  endfunction

  function automatic int free_slots(int ly, int cap);
    int n;
    n = 0;
    for (int i = 0; i < cap; i++)
      if (tags[ly][i] == 8'd0) n++;
    return n;
  endfunction

  task automatic predict_allocation(output alloc_result_t r);
    int ly, cap, pal, xs, x, fr, slot;
    logic [7:0] g;
    bit found;
    logic [31:0] addr, word;
    r = '0;
    ly = int'(in_layer);
    pal = 1;
    xs = 0;
    if (ly >= Layers) begin
      r.status = gtta_pkg::StNoSpace;
      return;
    end
    case (in_position)
      2'd0: pal = 1 + ly;
      2'd1: begin
        pal = 3 + ly;
        xs = 44 - int'(in_sprite_width) / 2;
      end
      2'd2: begin
        pal = 5 + ly;
        xs = 88 - int'(in_sprite_width);
      end
      default: ;
    endcase
    if (pal > 6) begin
      r.status = gtta_pkg::StBadPal;
      return;
    end
    cap = (capacity[ly] > MaxSlots) ? MaxSlots : int'(capacity[ly]);
    if (in_operation == gtta_pkg::OpReserve) begin
      if (int'(in_tile_count) > cap) begin
        r.status = gtta_pkg::StNoSpace;
        r.free_count = 13'(free_slots(ly, cap));
        return;
      end
      g = generation[ly];
      fr = 0;
      while (fr < int'(in_tile_count)) begin
        g = next_generation(g);
        for (int i = 0; i < cap; i++)
          if (tags[ly][i] == g) tags[ly][i] = 8'd0;
        fr = free_slots(ly, cap);
      end
      generation[ly] = next_generation(generation[ly]);
      r.free_count = 13'(fr);
    end else begin
      found = 0;
      slot = 0;
      for (int i = 0; i < cap && !found; i++)
        if (tags[ly][i] == 8'd0) begin
          found = 1;
          slot = i;
        end
      if (!found) begin
        r.status = gtta_pkg::StNoSpace;
        return;
      end
      tags[ly][slot] = generation[ly];
      x = xs + int'(in_column);
      if (x < Pitch) addr = 32'(int'(in_row) * Pitch + x);
      else addr = 32'((int'(in_row) + Pitch) * Pitch + x - Pitch);
      word = 32'(pal * PalStep + int'(name_base[ly]) + 2 * slot);
      r.tile_slot = 12'(slot);
      r.name_word = word[22:0];
      r.map_address = addr[12:0];
      r.map_write = !(ly == 2 && in_row >= TextRowLo && in_row <= TextRowHi);
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t got, exp_r;
    if (!rst_n) begin
      for (int l = 0; l < Layers; l++) begin
        for (int i = 0; i < MaxSlots; i++) tags[l][i] = 8'd0;
        generation[l] = 8'd0;
        name_base[l] = '0;
      end
      capacity[0] = 13'd3072;
      capacity[1] = 13'd1536;
      capacity[2] = 13'd1536;
      expected_q.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        got = '{out_status, out_free_count, out_tile_slot, out_name_word,
                out_map_address, out_map_write};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result status=%0d slot=%0d", out_status, out_tile_slot);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp st=%0d free=%0d slot=%0d word=%h addr=%0d wr=%0d",
                       exp_r.status, exp_r.free_count, exp_r.tile_slot, exp_r.name_word,
                       exp_r.map_address, exp_r.map_write,
                       "  got st=%0d free=%0d slot=%0d word=%h addr=%0d wr=%0d",
                       got.status, got.free_count, got.tile_slot, got.name_word,
                       got.map_address, got.map_write);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < FirstBaseIdx) capacity[cfg_index] = cfg_data[12:0];
        else if (cfg_index < gtta_pkg::NumCfg)
          name_base[cfg_index - FirstBaseIdx] = cfg_data;
      end
      if (start && !busy) begin
        predict_allocation(exp_r);
        expected_q.push_back(exp_r);
      end
      pending = expected_q.size();
    end
  end

endmodule

[tb/generation_tagged_tile_allocator_tb.sv]
`timescale 1ns / 1ps
module generation_tagged_tile_allocator_tb;

  localparam logic OpPlace = ~gtta_pkg::OpReserve;
  localparam logic OpReserve = gtta_pkg::OpReserve;
  localparam logic [2:0] RegCap0 = 3'd0;
  localparam logic [2:0] RegCap1 = 3'd1;
  localparam logic [2:0] RegCap2 = 3'd2;
  localparam logic [2:0] RegBase0 = 3'd3;
  localparam logic [2:0] RegBase1 = 3'd4;
  localparam logic [2:0] RegBase2 = 3'd5;
  localparam int StallLimit = 3000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [1:0]  in_layer;
  logic [1:0]  in_position;
  logic [12:0] in_tile_count;
  logic [6:0]  in_sprite_width;
  logic [6:0]  in_column;
  logic [5:0]  in_row;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [13:0] cfg_data;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [12:0] out_free_count;
  logic [11:0] out_tile_slot;
  logic [22:0] out_name_word;
  logic [12:0] out_map_address;
  logic        out_map_write;
  int          mismatches;
  int          pending;
  bit          no_idle;
  int          caps [3];

  generation_tagged_tile_allocator dut (.*);
  generation_tagged_tile_allocator_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    if (!no_idle)
      while ($urandom_range(0, 99) < 23) @(negedge clk);
  endtask

  task automatic issue(input logic op, input logic [1:0] ly, input logic [1:0] pos,
                       input logic [12:0] cnt, input logic [6:0] wid,
                       input logic [6:0] col, input logic [5:0] row);
    idle_gap();
    @(negedge clk);
    in_operation = op;
    in_layer = ly;
    in_position = pos;
    in_tile_count = cnt;
    in_sprite_width = wid;
    in_column = col;
    in_row = row;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    start = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    forever begin
      @(posedge clk);
      if (pending == 0 && !busy) break;
    end
  endtask

  task automatic run_phase(input int c0, input int c1, input int c2, input int b0,
                           input int b1, input int b2, input int n, input bit big);
    logic [1:0] ly;
    int cnt;
    drain();
    caps = '{c0, c1, c2};
    write_reg(RegCap0, 14'(c0));
    write_reg(RegCap1, 14'(c1));
    write_reg(RegCap2, 14'(c2));
    write_reg(RegBase0, 14'(b0));
    write_reg(RegBase1, 14'(b1));
    write_reg(RegBase2, 14'(b2));
    repeat (n) begin
      ly = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (big) cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096)
                                                 : $urandom_range(0, 40);
      else cnt = $urandom_range(0, caps[(ly == 3) ? 0 : ly] + 2);
      issue(($urandom_range(0, 99) < 65) ? OpPlace : OpReserve, ly,
            ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
            13'(cnt), 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
            6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_operation = 0;
    in_layer = 0;
    in_position = 0;
    in_tile_count = 0;
    in_sprite_width = 0;
    in_column = 0;
    in_row = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    no_idle = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    issue(OpPlace,   2'd0, 2'd0, 13'd0,    7'd0,   7'd0,   6'd0);
    issue(OpReserve, 2'd0, 2'd0, 13'd0,    7'd0,   7'd0,   6'd0);
    issue(OpReserve, 2'd0, 2'd1, 13'd4096, 7'd9,   7'd0,   6'd0);
    issue(OpReserve, 2'd1, 2'd0, 13'd1536, 7'd0,   7'd0,   6'd0);
    issue(OpPlace,   2'd1, 2'd1, 13'd0,    7'd127, 7'd127, 6'd63);
    issue(OpPlace,   2'd1, 2'd0, 13'd0,    7'd3,   7'd63,  6'd1);
    issue(OpReserve, 2'd2, 2'd0, 13'd1,    7'd0,   7'd0,   6'd0);
    issue(OpPlace,   2'd2, 2'd0, 13'd0,    7'd10,  7'd5,   6'd44);
    issue(OpPlace,   2'd2, 2'd1, 13'd0,    7'd0,   7'd0,   6'd53);
    issue(OpPlace,   2'd2, 2'd1, 13'd0,    7'd20,  7'd3,   6'd54);
    issue(OpPlace,   2'd2, 2'd1, 13'd0,    7'd1,   7'd1,   6'd43);
    issue(OpPlace,   2'd2, 2'd2, 13'd0,    7'd4,   7'd4,   6'd4);
    issue(OpReserve, 2'd2, 2'd2, 13'd2,    7'd4,   7'd4,   6'd4);
    issue(OpReserve, 2'd3, 2'd0, 13'd5,    7'd0,   7'd0,   6'd0);
    issue(OpPlace,   2'd3, 2'd1, 13'd0,    7'd0,   7'd0,   6'd0);
    issue(OpPlace,   2'd0, 2'd3, 13'd0,    7'd5,   7'd9,   6'd7);
    issue(OpReserve, 2'd0, 2'd0, 13'd3,    7'd0,   7'd0,   6'd0);
    issue(OpPlace,   2'd0, 2'd2, 13'd0,    7'd127, 7'd0,   6'd1);
    issue(OpPlace,   2'd0, 2'd2, 13'd0,    7'd0,   7'd127, 6'd2);
    issue(OpPlace,   2'd1, 2'd1, 13'd8191, 7'd100, 7'd10,  6'd30);
    issue(OpReserve, 2'd0, 2'd0, 13'd3072, 7'd0,   7'd0,   6'd0);

    run_phase(1, 1, 1, 0, 0, 0, 20, 0);
    no_idle = 1;
    run_phase($urandom_range(2, 40), $urandom_range(2, 40), $urandom_range(2, 40),
              $urandom_range(0, 16383), $urandom_range(0, 16383),
              $urandom_range(0, 16383), 35, 0);
    no_idle = 0;
    run_phase(4096, 4096, 4096, 16383, 16383, 16383, 15, 1);
    run_phase($urandom_range(8, 64), $urandom_range(8, 64), $urandom_range(8, 64),
              $urandom_range(0, 16383), $urandom_range(0, 16383),
              $urandom_range(0, 16383), 35, 0);
    run_phase(16, 3, 48, 0, 16383, 8191, 20, 0);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/gtta_pkg.sv
rtl/gtta_ram.sv
rtl/generation_tagged_tile_allocator.sv
tb/generation_tagged_tile_allocator_checker.sv
tb/generation_tagged_tile_allocator_tb.sv
